// ===== hw/rtl/mbos_pkg.sv =====
// ----------------------------------------------------------------------------
// mbos_pkg
// shared types, codes and constants of the masked box overlap scanner
// ----------------------------------------------------------------------------
package mbos_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int KIND_COUNT_DEF = 10;

    localparam int MASK_W  = 50;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 4;
    localparam int SLOTF_W = 3;
    localparam int IN_DW   = 64;
    localparam int OUT_DW  = 8;

    localparam logic [MASK_W-1:0] MASK_LOW_RST  = 50'd289656950571600;
    localparam logic [MASK_W-1:0] MASK_HIGH_RST = 50'd1161797150020;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_SCAN   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_MASK_LOW  = 1'b0,
        REG_MASK_HIGH = 1'b1
    } t_reg_idx;

    typedef enum logic {
        RES_HIT  = 1'b0,
        RES_DONE = 1'b1
    } t_res_kind;

    typedef struct packed {
        logic                notify;
        logic [KIND_W-1:0]   kind;
        logic [11:0]         h;
        logic [11:0]         w;
        logic signed [15:0]  y;
        logic signed [15:0]  x;
    } t_box;

    // mask bit for kind k notified when hitting kind o; kinds above nine read as 0
    function automatic logic pair_on(input logic [MASK_W-1:0] lo,
                                     input logic [MASK_W-1:0] hi,
                                     input logic [KIND_W-1:0] k,
                                     input logic [KIND_W-1:0] o);
        logic [5:0] idx;
        logic       bit_v;
        idx   = '0;
        bit_v = 1'b0;
        if (k <= 4'd9 && o <= 4'd9) begin
            if (k < 4'd5) begin
                idx   = 6'(k) * 6'd10 + 6'(o);
                bit_v = lo[idx];
            end else begin
                idx   = 6'(k - 4'd5) * 6'd10 + 6'(o);
                bit_v = hi[idx];
            end
        end
        return bit_v;
    endfunction

endpackage

// ===== hw/rtl/masked_box_overlap_scanner.sv =====
// ----------------------------------------------------------------------------
// masked_box_overlap_scanner
// box table with pairwise overlap scan and kind-pair notify mask
// ----------------------------------------------------------------------------
// input stream: one word per command, tuser holds the command, tdata the slot
// and box fields. write and free update the table and give no output word.
// scan walks every slot pair i<j in order, one pair per cycle while the output
// takes its hit words, out of the dual-read table memory; a pair whose hit goes
// both ways holds the walk until its second word is loaded. an overlapping
// pair of valid slots emits (i,j) if i notifies and the mask allows it, then
// (j,i) likewise, on the output stream, and every scan ends with a done word
// carrying tlast. a scan covers SLOT_COUNT*(SLOT_COUNT-1)/2 pairs (28 at
// eight slots). a new command is taken once the scan has put its done word in
// the output register; that register parts the two sides, so writes proceed
// while a word still waits. when the receiver stalls, the walk holds on the
// first pair that has a hit word to emit; pairs without hits keep moving.
// reset marks all slots invalid, loads the default masks and empties the
// output. the mask port may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module masked_box_overlap_scanner #(
    parameter int SLOT_COUNT = mbos_pkg::SLOT_COUNT_DEF,
    parameter int KIND_COUNT = mbos_pkg::KIND_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // slot, box_x, box_y, box_w, box_h, box_kind, notify_enabled
    input  logic [mbos_pkg::IN_DW-1:0]    i_s_axis_tdata,
    // cmd
    input  logic [mbos_pkg::CMD_W-1:0]    i_s_axis_tuser,
    // master side
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // notified_slot, partner_slot, zero pad
    output logic [mbos_pkg::OUT_DW-1:0]   o_m_axis_tdata,
    // result_kind
    output logic [0:0]                    o_m_axis_tuser,
    output logic                          o_m_axis_tlast,
    // mask registers
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [mbos_pkg::MASK_W-1:0]   i_cfg_data
);
    import mbos_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LAST_J = SW'(SLOT_COUNT - 1);
    localparam logic [SW-1:0] LAST_I = SW'(SLOT_COUNT - 2);

    // input word fields
    logic [SLOTF_W-1:0] in_slot;
    t_box               in_box;
    t_cmd               in_cmd;
    logic               in_acc;
    logic               slot_ok;

    assign in_slot       = i_s_axis_tdata[2:0];
    assign in_box.x      = i_s_axis_tdata[18:3];
    assign in_box.y      = i_s_axis_tdata[34:19];
    assign in_box.w      = i_s_axis_tdata[46:35];
    assign in_box.h      = i_s_axis_tdata[58:47];
    assign in_box.kind   = i_s_axis_tdata[62:59];
    assign in_box.notify = i_s_axis_tdata[63];
    assign in_cmd        = t_cmd'(i_s_axis_tuser);
    assign in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_ok       = {1'b0, in_slot} < 4'(SLOT_COUNT);

    // table memory and valid bits
    t_box                   r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  r_valid;
    logic [MASK_W-1:0]      r_mask_lo;
    logic [MASK_W-1:0]      r_mask_hi;

    // pair walk
    logic          r_issuing;
    logic [SW-1:0] r_i;
    logic [SW-1:0] r_j;
    logic          r_done_pend;

    // evaluation stage
    logic          r_pv;
    logic [SW-1:0] r_pi;
    logic [SW-1:0] r_pj;
    t_box          r_a;
    t_box          r_b;
    logic          r_va;
    logic          r_vb;
    logic          r_ab_done;

    // output register
    logic                r_ovalid;
    logic [SLOTF_W-1:0]  r_onot;
    logic [SLOTF_W-1:0]  r_opart;
    t_res_kind           r_okind;
    logic                r_olast;

    logic signed [16:0] ax_end, bx_end, ay_end, by_end;
    logic               ovl;
    logic               kinds_ok;
    logic               hit_ab, hit_ba;
    logic               out_ok;
    logic               consume, advance;
    logic               ld_ab, ld_ba, ld_done, set_ab_done;

    always_comb begin
        ax_end   = 17'(r_a.x) + $signed({5'b0, r_a.w});
        bx_end   = 17'(r_b.x) + $signed({5'b0, r_b.w});
        ay_end   = 17'(r_a.y) + $signed({5'b0, r_a.h});
        by_end   = 17'(r_b.y) + $signed({5'b0, r_b.h});
        ovl      = (17'(r_a.x) < bx_end) && (ax_end > 17'(r_b.x)) &&
                   (17'(r_a.y) < by_end) && (ay_end > 17'(r_b.y));
        kinds_ok = (r_a.kind < 4'(KIND_COUNT)) && (r_b.kind < 4'(KIND_COUNT));
        hit_ab   = r_pv && r_va && r_vb && ovl && kinds_ok && r_a.notify &&
                   pair_on(r_mask_lo, r_mask_hi, r_a.kind, r_b.kind);
        hit_ba   = r_pv && r_va && r_vb && ovl && kinds_ok && r_b.notify &&
                   pair_on(r_mask_lo, r_mask_hi, r_b.kind, r_a.kind);
        out_ok   = !r_ovalid || i_m_axis_tready;

        ld_ab       = 1'b0;
        ld_ba       = 1'b0;
        set_ab_done = 1'b0;
        consume     = 1'b0;
        if (r_pv) begin
            if (hit_ab && !r_ab_done) begin
                ld_ab       = out_ok;
                consume     = out_ok && !hit_ba;
                set_ab_done = out_ok && hit_ba;
            end else if (hit_ba) begin
                ld_ba   = out_ok;
                consume = out_ok;
            end else begin
                consume = 1'b1;
            end
        end
        advance = !r_pv || consume;
        ld_done = !r_pv && !r_issuing && r_done_pend && out_ok;
    end

    assign o_s_axis_tready = !(r_issuing || r_pv || r_done_pend);

    // memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (in_acc && in_cmd == CMD_WRITE && slot_ok) begin
            r_mem[in_slot[SW-1:0]] <= in_box;
        end
        if (advance) begin
            r_a <= r_mem[r_i];
            r_b <= r_mem[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_mask_lo   <= MASK_LOW_RST;
            r_mask_hi   <= MASK_HIGH_RST;
            r_issuing   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_done_pend <= 1'b0;
            r_pv        <= 1'b0;
            r_ab_done   <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_MASK_LOW:  r_mask_lo <= i_cfg_data;
                    REG_MASK_HIGH: r_mask_hi <= i_cfg_data;
                endcase
            end

            if (in_acc) begin
                unique case (in_cmd)
                    CMD_WRITE: if (slot_ok) r_valid[in_slot[SW-1:0]] <= 1'b1;
                    CMD_FREE:  if (slot_ok) r_valid[in_slot[SW-1:0]] <= 1'b0;
                    CMD_SCAN: begin
                        r_issuing   <= 1'b1;
                        r_i         <= '0;
                        r_j         <= SW'(1);
                        r_done_pend <= 1'b1;
                    end
                    default: ;
                endcase
            end

            if (advance) begin
                r_pv <= r_issuing;
                r_pi <= r_i;
                r_pj <= r_j;
                r_va <= r_valid[r_i];
                r_vb <= r_valid[r_j];
                if (r_issuing) begin
                    if (r_j == LAST_J) begin
                        if (r_i == LAST_I) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_i <= r_i + SW'(1);
                            r_j <= r_i + SW'(2);
                        end
                    end else begin
                        r_j <= r_j + SW'(1);
                    end
                end
            end

            if (consume) begin
                r_ab_done <= 1'b0;
            end else if (set_ab_done) begin
                r_ab_done <= 1'b1;
            end

            if (ld_ab) begin
                r_ovalid <= 1'b1;
                r_onot   <= SLOTF_W'(r_pi);
                r_opart  <= SLOTF_W'(r_pj);
                r_okind  <= RES_HIT;
                r_olast  <= 1'b0;
            end else if (ld_ba) begin
                r_ovalid <= 1'b1;
                r_onot   <= SLOTF_W'(r_pj);
                r_opart  <= SLOTF_W'(r_pi);
                r_okind  <= RES_HIT;
                r_olast  <= 1'b0;
            end else if (ld_done) begin
                r_ovalid    <= 1'b1;
                r_onot      <= '0;
                r_opart     <= '0;
                r_okind     <= RES_DONE;
                r_olast     <= 1'b1;
                r_done_pend <= 1'b0;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {2'b00, r_opart, r_onot};
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_issuing || r_pv) |-> !o_s_axis_tready)
        else $error("command taken during scan");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_pi < r_pj))
        else $error("pair out of order");

    a_ab_done_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ab_done |-> r_pv)
        else $error("half-emitted pair without stage data");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_issuing) |-> r_done_pend)
        else $error("scan ended without pending done");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_done |=> (r_ovalid && r_olast && !r_pv && !r_issuing))
        else $error("done word not last");
`endif

endmodule
